### rtl/core/dday_pkg.sv
// ----------------------------------------------------------------------------
// dday_pkg: shared types and constants for the date day difference core
// Request and result payload structs, order codes, the month start table and
// the reciprocal used to divide by 25.
// ----------------------------------------------------------------------------
`default_nettype none

package dday_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int ORDER_W  = 2;
    localparam int COUNT_W  = 22;
    localparam int SERIAL_W = 23;
    localparam int MOFF_W   = 9;

    localparam logic [ORDER_W-1:0] ORDER_FIRST_EARLIER = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL         = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_FIRST_LATER   = 2'd2;

    // x / 25 == (x * DIV25_MUL) >> DIV25_SHIFT for every 12-bit x.
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;

    typedef struct packed {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
    } t_date_pair;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [COUNT_W-1:0] day_count;
    } t_day_diff;

    // Days before the first of month m in a common year. Months past
    // December count 31 days each.
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] v;
        unique case (m)
            4'd0, 4'd1: v = 9'd0;
            4'd2:       v = 9'd31;
            4'd3:       v = 9'd59;
            4'd4:       v = 9'd90;
            4'd5:       v = 9'd120;
            4'd6:       v = 9'd151;
            4'd7:       v = 9'd181;
            4'd8:       v = 9'd212;
            4'd9:       v = 9'd243;
            4'd10:      v = 9'd273;
            4'd11:      v = 9'd304;
            4'd12:      v = 9'd334;
            4'd13:      v = 9'd365;
            4'd14:      v = 9'd396;
            default:    v = 9'd427;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/dday_serial.sv
// ----------------------------------------------------------------------------
// dday_serial: day serial of one date
// Days of all whole years before the year, plus the days of the months before
// the month (with the leap day after February), plus the day field.
// ----------------------------------------------------------------------------
`default_nettype none

module dday_serial
    import dday_pkg::*;
(
    input  wire logic [DAY_W-1:0]    i_day,
    input  wire logic [MONTH_W-1:0]  i_month,
    input  wire logic [YEAR_W-1:0]   i_year,
    output logic      [SERIAL_W-1:0] o_serial
);

    logic [YEAR_W-1:0]   prev_year;
    logic [11:0]         prev_q4;
    logic [24:0]         prev_prod;
    logic [7:0]          prev_q100;
    logic [SERIAL_W-1:0] year_days;
    logic [11:0]         year_q4;
    logic [24:0]         year_prod;
    logic [7:0]          year_q100;
    logic [11:0]         year_r25;
    logic                div4;
    logic                div100;
    logic                leap;
    logic                add_leap_day;

    // Leap days before year y are p/4 - p/100 + p/400 with p = y - 1, and
    // p/100 is (p/4)/25.
    assign prev_year = i_year - 14'd1;
    assign prev_q4   = prev_year[YEAR_W-1:2];
    assign prev_prod = 25'(prev_q4) * 25'(DIV25_MUL);
    assign prev_q100 = prev_prod[24:DIV25_SHIFT];

    always_comb begin
        if (i_year == '0) begin
            year_days = '0;
        end else begin
            year_days = SERIAL_W'(i_year) * 23'd365 + 23'd1 + SERIAL_W'(prev_q4)
                      - SERIAL_W'(prev_q100) + SERIAL_W'(prev_q100[7:2]);
        end
    end

    // Leap test: y divisible by 4, and not by 100 unless also by 400.
    assign year_q4   = i_year[YEAR_W-1:2];
    assign year_prod = 25'(year_q4) * 25'(DIV25_MUL);
    assign year_q100 = year_prod[24:DIV25_SHIFT];
    assign year_r25  = year_q4 - 12'(year_q100) * 12'd25;
    assign div4      = (i_year[1:0] == 2'd0);
    assign div100    = div4 && (year_r25 == '0);
    assign leap      = div4 && (!div100 || (year_q100[1:0] == 2'd0));

    assign add_leap_day = leap && (i_month > 4'd2);

    assign o_serial = year_days + SERIAL_W'(month_offset(i_month))
                    + SERIAL_W'(add_leap_day) + SERIAL_W'(i_day);

endmodule

`default_nettype wire

### rtl/core/date_day_difference_core.sv
// Each accepted request passes the input register, then the result register, to o_out_valid.
// Throughput: one request per cycle; the input register and the result
// register form a two-stage pipeline that stalls only when the result waits.
// Reset (synchronous, active low) empties both stages; there is no other state.
// ----------------------------------------------------------------------------
// date_day_difference_core: order and day distance of two Gregorian dates
// Both day serials are formed from the registered request, subtracted and
// saturated into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module date_day_difference_core
    import dday_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_date_pair i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_day_diff       o_out_data
);

    logic                r_s1_vld;
    t_date_pair          r_s1;
    logic                r_out_vld;
    t_day_diff           r_out;

    logic                s1_advance;
    logic [SERIAL_W-1:0] serial_first;
    logic [SERIAL_W-1:0] serial_second;
    logic [SERIAL_W-1:0] diff;
    t_day_diff           n_out;

    assign s1_advance = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_s1_vld || s1_advance;

    dday_serial u_serial_first (
        .i_day    (r_s1.first_day),
        .i_month  (r_s1.first_month),
        .i_year   (r_s1.first_year),
        .o_serial (serial_first)
    );

    dday_serial u_serial_second (
        .i_day    (r_s1.second_day),
        .i_month  (r_s1.second_month),
        .i_year   (r_s1.second_year),
        .o_serial (serial_second)
    );

    assign diff = (serial_first > serial_second) ? (serial_first - serial_second)
                                                 : (serial_second - serial_first);

    always_comb begin
        // The order follows the fields, year first, even when bad days or
        // months make the serials disagree.
        priority if (r_s1.first_year != r_s1.second_year) begin
            n_out.order = (r_s1.first_year < r_s1.second_year) ? ORDER_FIRST_EARLIER
                                                                : ORDER_FIRST_LATER;
        end else if (r_s1.first_month != r_s1.second_month) begin
            n_out.order = (r_s1.first_month < r_s1.second_month) ? ORDER_FIRST_EARLIER
                                                                 : ORDER_FIRST_LATER;
        end else if (r_s1.first_day != r_s1.second_day) begin
            n_out.order = (r_s1.first_day < r_s1.second_day) ? ORDER_FIRST_EARLIER
                                                             : ORDER_FIRST_LATER;
        end else begin
            n_out.order = ORDER_EQUAL;
        end

        if (n_out.order == ORDER_EQUAL) begin
            n_out.day_count = '0;
        end else if (diff[SERIAL_W-1]) begin
            n_out.day_count = '1;
        end else begin
            n_out.day_count = diff[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (s1_advance) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_data;
        end
        if (s1_advance && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: date day difference core
// Drives date pair requests through the valid/ready input, predicts the
// order and day distance of each pair, and checks every result in order,
// field by field. Both sides idle in random bursts except in the last part.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import dday_pkg::*;

    localparam longint unsigned COUNT_LIMIT    = (64'd1 << COUNT_W) - 1;
    localparam int              WATCHDOG_LIMIT = 1000;
    localparam int              DRAIN_CYCLES   = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_date_pair i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_day_diff  o_out_data;

    t_day_diff  pending_diffs[$];
    int         error_count;
    int         quiet_cycles;
    int         stall_left;
    bit         no_idle;

    date_day_difference_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Calendar arithmetic for the prediction
    // ------------------------------------------------------------------
    function automatic bit leap_year(input longint unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // Months past December count 31 days each.
    function automatic int month_length(input int m, input longint unsigned y);
        int len;
        case (m)
            2: begin
                len = leap_year(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                len = 30;
            end
            default: begin
                len = 31;
            end
        endcase
        return len;
    endfunction

    function automatic longint unsigned day_serial(input logic [DAY_W-1:0] d,
                                                   input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0] y);
        longint unsigned yy;
        longint unsigned prev;
        longint unsigned total;
        yy = 64'(y);
        total = 0;
        if (yy != 0) begin
            prev = yy - 1;
            total = 365 * yy + 1 + prev / 4 - prev / 100 + prev / 400;
        end
        for (int i = 1; i < int'(m); i++) begin
            total += 64'(month_length(i, yy));
        end
        return total + 64'(d);
    endfunction

    function automatic t_day_diff date_distance(input t_date_pair p);
        t_day_diff       r;
        longint unsigned s1;
        longint unsigned s2;
        longint unsigned span;
        if (p.first_year != p.second_year) begin
            r.order = (p.first_year < p.second_year) ? ORDER_FIRST_EARLIER : ORDER_FIRST_LATER;
        end else if (p.first_month != p.second_month) begin
            r.order = (p.first_month < p.second_month) ? ORDER_FIRST_EARLIER : ORDER_FIRST_LATER;
        end else if (p.first_day != p.second_day) begin
            r.order = (p.first_day < p.second_day) ? ORDER_FIRST_EARLIER : ORDER_FIRST_LATER;
        end else begin
            r.order = ORDER_EQUAL;
        end
        s1 = day_serial(p.first_day, p.first_month, p.first_year);
        s2 = day_serial(p.second_day, p.second_month, p.second_year);
        span = (s1 > s2) ? (s1 - s2) : (s2 - s1);
        if (r.order == ORDER_EQUAL) begin
            span = 0;
        end
        if (span > COUNT_LIMIT) begin
            span = COUNT_LIMIT;
        end
        r.day_count = span[COUNT_W-1:0];
        return r;
    endfunction

    function automatic t_date_pair date_pair(input int d1, input int m1, input int y1,
                                             input int d2, input int m2, input int y2);
        t_date_pair p;
        p.first_day    = d1[DAY_W-1:0];
        p.first_month  = m1[MONTH_W-1:0];
        p.first_year   = y1[YEAR_W-1:0];
        p.second_day   = d2[DAY_W-1:0];
        p.second_month = m2[MONTH_W-1:0];
        p.second_year  = y2[YEAR_W-1:0];
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Request driver and result side
    // ------------------------------------------------------------------
    task automatic send_request(input t_date_pair p);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic pick_valid_date(output int d, output int m, output int y);
        y = $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_length(m, y));
    endtask

    task automatic send_valid_pairs(input int count);
        int d1, m1, y1, d2, m2, y2;
        repeat (count) begin
            pick_valid_date(d1, m1, y1);
            pick_valid_date(d2, m2, y2);
            case ($urandom_range(0, 7))
                0: begin
                    d2 = d1;
                    m2 = m1;
                    y2 = y1;
                end
                1: begin
                    m2 = m1;
                    y2 = y1;
                    d2 = $urandom_range(1, month_length(m2, y2));
                end
                2: begin
                    y2 = y1;
                end
                3: begin
                    y2 = y1 + $urandom_range(0, 4) - 2;
                    if (y2 < 1) y2 = 1;
                    if (y2 > 9999) y2 = 9999;
                    d2 = $urandom_range(1, month_length(m2, y2));
                end
                4: begin
                    // Around the end of February in a century year.
                    y1 = 100 * $urandom_range(1, 99);
                    y2 = y1;
                    m1 = 2;
                    d1 = $urandom_range(28, month_length(2, y1));
                    m2 = 3;
                    d2 = 1;
                end
                default: begin
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                send_request(date_pair(d2, m2, y2, d1, m1, y1));
            end else begin
                send_request(date_pair(d1, m1, y1, d2, m2, y2));
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (!no_idle && i_rst_n && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 5);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_day_diff want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pending_diffs.push_back(date_distance(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_diffs.size() == 0) begin
                    $error("result with no request waiting: order %0d, day_count %0d",
                           o_out_data.order, o_out_data.day_count);
                    error_count++;
                end else begin
                    want = pending_diffs.pop_front();
                    if (o_out_data.order !== want.order) begin
                        $error("order: expected %0d, actual %0d",
                               want.order, o_out_data.order);
                        error_count++;
                    end
                    if (o_out_data.day_count !== want.day_count) begin
                        $error("day_count: expected %0d, actual %0d",
                               want.day_count, o_out_data.day_count);
                        error_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_calendar_dates();
        send_request(date_pair(15, 6, 2000, 15, 6, 2000));
        send_request(date_pair(1, 1, 1, 31, 12, 9999));
        send_request(date_pair(31, 12, 9999, 1, 1, 1));
        send_request(date_pair(29, 2, 2000, 1, 3, 2000));
        send_request(date_pair(28, 2, 1900, 1, 3, 1900));
        send_request(date_pair(28, 2, 2004, 1, 3, 2004));
        send_request(date_pair(1, 3, 2001, 28, 2, 2001));
        send_request(date_pair(20, 7, 2023, 5, 7, 2023));
        send_request(date_pair(31, 12, 1999, 1, 1, 2000));
    endtask

    task automatic test_corner_fields();
        // Equal field values give a zero count even with invalid fields.
        send_request(date_pair(0, 0, 0, 0, 0, 0));
        send_request(date_pair(31, 15, 16383, 31, 15, 16383));
        // Widest spans, which saturate the count.
        send_request(date_pair(0, 0, 0, 31, 15, 16383));
        send_request(date_pair(31, 15, 16383, 0, 0, 0));
        send_request(date_pair(1, 1, 1, 1, 1, 16383));
        // Day zero and month zero.
        send_request(date_pair(0, 5, 2020, 30, 4, 2020));
        send_request(date_pair(10, 0, 2020, 10, 1, 2020));
        // Months past December.
        send_request(date_pair(1, 13, 2020, 1, 1, 2021));
        send_request(date_pair(1, 15, 2023, 1, 1, 2024));
        send_request(date_pair(17, 14, 2400, 3, 2, 2401));
        // Year zero is a leap year.
        send_request(date_pair(1, 3, 0, 1, 3, 1));
        // Order by fields while the serials run the other way.
        send_request(date_pair(31, 2, 2021, 1, 3, 2021));
        send_request(date_pair(1, 3, 2021, 31, 2, 2021));
    endtask

    task automatic test_random_valid_dates();
        send_valid_pairs(650);
    endtask

    task automatic test_random_raw_fields();
        t_date_pair p;
        repeat (150) begin
            p.first_day    = DAY_W'($urandom_range(0, 31));
            p.first_month  = MONTH_W'($urandom_range(0, 15));
            p.first_year   = YEAR_W'($urandom_range(0, 16383));
            p.second_day   = DAY_W'($urandom_range(0, 31));
            p.second_month = MONTH_W'($urandom_range(0, 15));
            p.second_year  = ($urandom_range(0, 3) == 0) ? p.first_year
                                                         : YEAR_W'($urandom_range(0, 16383));
            send_request(p);
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        send_valid_pairs(130);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        error_count  = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        no_idle      = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_calendar_dates();
        test_corner_fields();
        test_random_valid_dates();
        test_random_raw_fields();
        test_back_to_back();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_diffs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
